>>> hdl/seven_segment_two_wire_writer_assert.svh
// Assertion macros for the seven-segment two-wire writer.
// Used by the top level; needs nothing else.
`ifndef SEVEN_SEGMENT_TWO_WIRE_WRITER_ASSERT_SVH
`define SEVEN_SEGMENT_TWO_WIRE_WRITER_ASSERT_SVH

// Property that is checked only outside reset.
`define SSW_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property that is checked at every edge, reset included.
`define SSW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hdl/ssw_pkg.sv
// Shared types, constants and the segment table for the two-wire writer.
// No dependencies.
package ssw_pkg;

  localparam int DIGIT_COUNT  = 4;
  localparam int INPUT_DIGITS = 4;
  localparam int DIGIT_W      = 4;
  localparam int BYTE_W       = 8;
  localparam int SEG_IDX_W    = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

  // Bytes placed on the bus.
  localparam logic [BYTE_W-1:0] CMD_DATA  = 8'h40;
  localparam logic [BYTE_W-1:0] CMD_ADDR  = 8'hC0;
  localparam logic [BYTE_W-1:0] CTRL_BASE = 8'h80;

  // Frame codes of one update.
  localparam logic [1:0] FRAME_DATA = 2'd0;
  localparam logic [1:0] FRAME_ADDR = 2'd1;
  localparam logic [1:0] FRAME_CTRL = 2'd2;
  localparam logic [1:0] FRAME_END  = 2'd3;

  // Byte count of the address frame: the address byte and the digits.
  localparam logic [2:0] ADDR_FRAME_BYTES = 3'(1 + DIGIT_COUNT);
  localparam logic [2:0] ONE_BYTE         = 3'd1;
  localparam logic [3:0] BITS_PER_BYTE    = 4'd8;

  // Configuration register indexes and reset values.
  localparam logic REG_BRIGHTNESS = 1'b0;
  localparam logic REG_DISP_EN    = 1'b1;
  localparam logic [2:0] BRIGHT_RESET = 3'd7;
  localparam logic       DISP_EN_RESET = 1'b1;

  typedef struct packed {
    logic [2:0] brightness;
    logic       display_enable;
  } ssw_cfg_t;

  // One result beat, clock_line in the lowest bit.
  typedef struct packed {
    logic accepted;
    logic busy_res;
    logic data_line;
    logic clock_line;
  } ssw_result_t;

  // Decimal digit to segment pattern; values above nine are blank.
  function automatic logic [BYTE_W-1:0] seg_of(input logic [DIGIT_W-1:0] d);
    logic [BYTE_W-1:0] s;
    case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h6F;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

>>> hdl/ssw_cfg.sv
// APB-style register file holding brightness and the display enable bit.
// Depends on ssw_pkg.
module ssw_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output ssw_pkg::ssw_cfg_t cfg
);
  import ssw_pkg::*;

  logic [2:0] brightness_r;
  logic       disp_en_r;
  logic       wr_en;
  logic       reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[2];

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r <= BRIGHT_RESET;
      disp_en_r    <= DISP_EN_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_BRIGHTNESS: brightness_r <= pwdata[2:0];
        REG_DISP_EN:    disp_en_r    <= pwdata[0];
        default:        ;
      endcase
    end
  end

  // Read data.
  always_comb begin
    unique case (reg_idx)
      REG_BRIGHTNESS: prdata = {29'd0, brightness_r};
      REG_DISP_EN:    prdata = {31'd0, disp_en_r};
      default:        prdata = 32'd0;
    endcase
  end

  assign cfg.brightness     = brightness_r;
  assign cfg.display_enable = disp_en_r;

endmodule

>>> hdl/ssw_seq.sv
// Bus sequencer: frame, byte and bit counters, the shift register, the
// segment store and the held line levels. Depends on ssw_pkg.
module ssw_seq (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      step,
  input  logic                                      op_request,
  input  logic [ssw_pkg::INPUT_DIGITS-1:0][ssw_pkg::DIGIT_W-1:0] digits,
  input  ssw_pkg::ssw_cfg_t                         cfg,
  output ssw_pkg::ssw_result_t                      result_nxt,
  output logic                                      busy
);
  import ssw_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ARMED, ST_START_A, ST_START_B, ST_BIT_LOW, ST_BIT_HIGH,
    ST_ACK_LOW, ST_ACK_HIGH, ST_STOP_A, ST_STOP_B, ST_STOP_C
  } state_t;

  state_t             state_r, state_nxt;
  logic [1:0]         frame_r, frame_nxt;
  logic [2:0]         byte_r, byte_nxt;
  logic [3:0]         bit_r, bit_nxt;
  logic [BYTE_W-1:0]  shift_r, shift_nxt;
  logic               clk_lvl_r, clk_lvl_nxt;
  logic               dat_lvl_r, dat_lvl_nxt;
  logic               accepted;

  logic [BYTE_W-1:0]  store_r [DIGIT_COUNT];

  logic [2:0]         byte_inc;
  logic [2:0]         load_num;
  logic [2:0]         store_pos;
  logic [SEG_IDX_W-1:0] store_idx;
  logic [BYTE_W-1:0]  loaded;
  logic [2:0]         frame_bytes;
  logic [1:0]         frame_inc;
  logic [3:0]         bit_inc;
  logic [BYTE_W-1:0]  shift_dn;

  assign busy = (state_r != ST_IDLE);

  // Byte to load: the first of a frame at the start, else the next one.
  assign byte_inc  = byte_r + 3'd1;
  assign load_num  = (state_r == ST_START_B) ? 3'd0 : byte_inc;
  assign store_pos = load_num - 3'd1;
  assign store_idx = store_pos[SEG_IDX_W-1:0];

  always_comb begin
    case (frame_r)
      FRAME_DATA: loaded = CMD_DATA;
      FRAME_ADDR: begin
        if (load_num == 3'd0) begin
          loaded = CMD_ADDR;
        end else if (store_pos < 3'(DIGIT_COUNT)) begin
          loaded = store_r[store_idx];
        end else begin
          loaded = '0;
        end
      end
      FRAME_CTRL: loaded = CTRL_BASE | {4'd0, cfg.display_enable, cfg.brightness};
      default:    loaded = '0;
    endcase
  end

  assign frame_bytes = (frame_r == FRAME_ADDR) ? ADDR_FRAME_BYTES : ONE_BYTE;
  assign frame_inc   = frame_r + 2'd1;
  assign bit_inc     = bit_r + 4'd1;
  assign shift_dn    = shift_r >> 1;

  // Next state of the sequencer for one beat.
  always_comb begin
    state_nxt   = state_r;
    frame_nxt   = frame_r;
    byte_nxt    = byte_r;
    bit_nxt     = bit_r;
    shift_nxt   = shift_r;
    clk_lvl_nxt = clk_lvl_r;
    dat_lvl_nxt = dat_lvl_r;
    accepted    = 1'b0;
    if (op_request) begin
      if (state_r == ST_IDLE) begin
        frame_nxt = FRAME_DATA;
        byte_nxt  = 3'd0;
        bit_nxt   = 4'd0;
        state_nxt = ST_ARMED;
        accepted  = 1'b1;
      end
    end else begin
      unique case (state_r)
        ST_IDLE: ;
        ST_ARMED: begin
          state_nxt = ST_START_A; clk_lvl_nxt = 1'b1; dat_lvl_nxt = 1'b1;
        end
        ST_START_A: begin
          state_nxt = ST_START_B; clk_lvl_nxt = 1'b1; dat_lvl_nxt = 1'b0;
        end
        ST_START_B: begin
          byte_nxt    = 3'd0;
          bit_nxt     = 4'd0;
          shift_nxt   = loaded;
          state_nxt   = ST_BIT_LOW;
          clk_lvl_nxt = 1'b0;
          dat_lvl_nxt = loaded[0];
        end
        ST_BIT_LOW: begin
          state_nxt = ST_BIT_HIGH; clk_lvl_nxt = 1'b1;
        end
        ST_BIT_HIGH: begin
          shift_nxt   = shift_dn;
          bit_nxt     = bit_inc;
          clk_lvl_nxt = 1'b0;
          if (bit_inc >= BITS_PER_BYTE) begin
            state_nxt   = ST_ACK_LOW;
            dat_lvl_nxt = 1'b1;
          end else begin
            state_nxt   = ST_BIT_LOW;
            dat_lvl_nxt = shift_dn[0];
          end
        end
        ST_ACK_LOW: begin
          state_nxt = ST_ACK_HIGH; clk_lvl_nxt = 1'b1; dat_lvl_nxt = 1'b1;
        end
        ST_ACK_HIGH: begin
          byte_nxt    = byte_inc;
          clk_lvl_nxt = 1'b0;
          if (byte_inc != 3'd0 && byte_inc < frame_bytes) begin
            bit_nxt     = 4'd0;
            shift_nxt   = loaded;
            state_nxt   = ST_BIT_LOW;
            dat_lvl_nxt = loaded[0];
          end else begin
            state_nxt = ST_STOP_A;
          end
        end
        ST_STOP_A: begin
          state_nxt = ST_STOP_B; clk_lvl_nxt = 1'b0; dat_lvl_nxt = 1'b0;
        end
        ST_STOP_B: begin
          state_nxt = ST_STOP_C; clk_lvl_nxt = 1'b1; dat_lvl_nxt = 1'b0;
        end
        ST_STOP_C: begin
          clk_lvl_nxt = 1'b1;
          dat_lvl_nxt = 1'b1;
          if (frame_inc == FRAME_END || frame_inc == FRAME_DATA) begin
            frame_nxt = FRAME_DATA;
            state_nxt = ST_IDLE;
          end else begin
            frame_nxt = frame_inc;
            state_nxt = ST_START_A;
          end
        end
        default: state_nxt = ST_IDLE;
      endcase
    end
  end

  // Result of this beat, taken from the updated levels.
  assign result_nxt.accepted   = accepted;
  assign result_nxt.busy_res   = (state_nxt != ST_IDLE);
  assign result_nxt.data_line  = dat_lvl_nxt;
  assign result_nxt.clock_line = clk_lvl_nxt;

  // State, counters and held levels.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      frame_r   <= FRAME_DATA;
      byte_r    <= 3'd0;
      bit_r     <= 4'd0;
      shift_r   <= '0;
      clk_lvl_r <= 1'b0;
      dat_lvl_r <= 1'b0;
    end else if (step) begin
      state_r   <= state_nxt;
      frame_r   <= frame_nxt;
      byte_r    <= byte_nxt;
      bit_r     <= bit_nxt;
      shift_r   <= shift_nxt;
      clk_lvl_r <= clk_lvl_nxt;
      dat_lvl_r <= dat_lvl_nxt;
    end
  end

  // Segment store, written by an accepted request; positions without a
  // digit input are blank.
  always_ff @(posedge clk) begin
    if (step && accepted) begin
      for (int k = 0; k < DIGIT_COUNT; k++) begin
        if (k < INPUT_DIGITS) begin
          store_r[k] <= seg_of(digits[k % INPUT_DIGITS]);
        end else begin
          store_r[k] <= '0;
        end
      end
    end
  end

endmodule

>>> hdl/seven_segment_two_wire_writer.sv
// Top level of the seven-segment two-wire writer: register file, sequencer
// and the result register. Depends on ssw_pkg, ssw_cfg, ssw_seq and the
// assertion header.
//
//   channel   direction  beat contents
//   in_       slave      tuser: operation; tdata: four digits
//   out_      master     tdata: clock, data, busy, accepted
//   cfg_      APB        brightness at 0x0, display enable at 0x4
//
// A new beat is taken in each cycle while the output register is empty or being read.
// The sequencer updates at the input beat and its result lands in the
// output register on the same edge.
// The input is taken while the output register is empty or being read.
// Reset clears the sequencer, the levels and the output valid flag, and loads
// the register reset values; the segment store is written by the first request.
module seven_segment_two_wire_writer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // digit_first, digit_second, digit_third, digit_fourth
  input  logic [0:0]  in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // clock_line, data_line, busy_res, accepted, zero pad
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import ssw_pkg::*;

  `include "seven_segment_two_wire_writer_assert.svh"

  ssw_cfg_t    cfg;
  ssw_result_t result_nxt;
  ssw_result_t out_data_r;
  logic        out_valid_r;
  logic        in_fire;
  logic        busy;
  logic [INPUT_DIGITS-1:0][DIGIT_W-1:0] digits;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign digits    = in_tdata[INPUT_DIGITS*DIGIT_W-1:0];

  ssw_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  ssw_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (in_fire),
    .op_request (in_tuser[0]),
    .digits     (digits),
    .cfg        (cfg),
    .result_nxt (result_nxt),
    .busy       (busy)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= result_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_data_r};

  // A request taken while idle reports itself as accepted.
  `SSW_ASSERT(a_req_accepted, clk, rst_n, (in_fire && in_tuser[0] && !busy) |=> (out_valid_r && out_data_r.accepted && out_data_r.busy_res), "idle request not accepted")
  // A tick never reports an accepted request.
  `SSW_ASSERT(a_tick_not_accepted, clk, rst_n, (in_fire && !in_tuser[0]) |=> !out_data_r.accepted, "tick reported as accepted")
  // A waiting result is never overwritten by a new input beat.
  `SSW_ASSERT_ALWAYS(a_no_overwrite, clk, (out_valid_r && !out_tready) |-> !in_tready, "input taken over a stalled result")

endmodule

>>> tb/tb_seven_segment_two_wire_writer.sv
// Self-checking testbench for the seven-segment two-wire writer: a scoreboard
// predicts the bus levels of every beat and checks each result beat.
// Depends on ssw_pkg and the seven_segment_two_wire_writer top level.
module tb_seven_segment_two_wire_writer;
  timeunit 1ns;
  timeprecision 1ps;

  import ssw_pkg::*;

  // Beat kinds carried on in_tuser.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SHOW = 1'b1;

  // Register byte addresses on the configuration port.
  localparam logic [2:0] BRIGHT_ADDR = {REG_BRIGHTNESS, 2'b00};
  localparam logic [2:0] ENABLE_ADDR = {REG_DISP_EN, 2'b00};

  localparam int PHASES          = 7;
  localparam int BEATS_PER_PHASE = 133;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int HOLD_AT_RESULT  = 250;
  localparam int HOLD_CYCLES     = 80;
  localparam int MAX_REPORTS     = 10;

  // Segment patterns for decimal digits; codes above nine are blank.
  localparam logic [7:0] DIGIT_GLYPHS [0:15] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
    8'h7F, 8'h6F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // Held line states of one display update.
  typedef enum logic [3:0] {
    LINK_IDLE, LINK_ARMED, LINK_START_A, LINK_START_B, LINK_BIT_LOW,
    LINK_BIT_HIGH, LINK_ACK_LOW, LINK_ACK_HIGH, LINK_STOP_A, LINK_STOP_B,
    LINK_STOP_C
  } link_state_t;

  // Predicts the bus levels and holds the expected result beats.
  class link_scoreboard;
    link_state_t state;
    logic [1:0]  frame;
    logic [2:0]  byte_idx;
    logic [3:0]  bit_idx;
    logic [7:0]  shreg;
    logic [7:0]  seg_bytes [DIGIT_COUNT];
    logic        scl;
    logic        sda;
    logic [2:0]  bright;
    logic        disp_on;
    ssw_result_t levels_q[$];
    int          mismatch_count;
    int          beats_checked;
    int          shows_taken;
    int          shows_refused;
    int          idle_ticks;
    int          updates_done;

    function new();
      state    = LINK_IDLE;
      frame    = FRAME_DATA;
      byte_idx = '0;
      bit_idx  = '0;
      shreg    = '0;
      scl      = 1'b0;
      sda      = 1'b0;
      bright   = BRIGHT_RESET;
      disp_on  = DISP_EN_RESET;
      foreach (seg_bytes[k]) seg_bytes[k] = '0;
    endfunction

    function bit is_busy();
      return state != LINK_IDLE;
    endfunction

    function int pending_count();
      return levels_q.size();
    endfunction

    function void set_config(logic [2:0] addr, logic [31:0] value);
      if (addr == BRIGHT_ADDR) begin
        bright = value[2:0];
      end else if (addr == ENABLE_ADDR) begin
        disp_on = value[0];
      end
    endfunction

    function void log_mismatch(string what, logic [31:0] want, logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
        $display("[%0t] MISMATCH %s: expected %0h, got %0h", $realtime, what, want, got);
      end
    endfunction

    // Byte that the current frame sends at the current byte position.
    function logic [7:0] next_bus_byte();
      case (frame)
        FRAME_DATA: return CMD_DATA;
        FRAME_ADDR: begin
          if (byte_idx == 3'd0) begin
            return CMD_ADDR;
          end
          if (int'(byte_idx) - 1 < DIGIT_COUNT) begin
            return seg_bytes[int'(byte_idx) - 1];
          end
          return 8'h00;
        end
        FRAME_CTRL: return CTRL_BASE | {4'b0000, disp_on, bright};
        default:    return 8'h00;
      endcase
    endfunction

    function void drive_bit();
      state = LINK_BIT_LOW;
      scl   = 1'b0;
      sda   = shreg[0];
    endfunction

    // One tick of an update in progress: move to the next held line state.
    function void step_bus();
      logic [2:0] frame_len;
      frame_len = (frame == FRAME_ADDR) ? ADDR_FRAME_BYTES : ONE_BYTE;
      case (state)
        LINK_ARMED: begin
          state = LINK_START_A; scl = 1'b1; sda = 1'b1;
        end
        LINK_START_A: begin
          state = LINK_START_B; scl = 1'b1; sda = 1'b0;
        end
        LINK_START_B: begin
          byte_idx = '0;
          bit_idx  = '0;
          shreg    = next_bus_byte();
          drive_bit();
        end
        LINK_BIT_LOW: begin
          state = LINK_BIT_HIGH; scl = 1'b1;
        end
        LINK_BIT_HIGH: begin
          shreg   = shreg >> 1;
          bit_idx = bit_idx + 4'd1;
          if (bit_idx >= BITS_PER_BYTE) begin
            state = LINK_ACK_LOW; scl = 1'b0; sda = 1'b1;
          end else begin
            drive_bit();
          end
        end
        LINK_ACK_LOW: begin
          state = LINK_ACK_HIGH; scl = 1'b1; sda = 1'b1;
        end
        LINK_ACK_HIGH: begin
          byte_idx = byte_idx + 3'd1;
          if (byte_idx != 3'd0 && byte_idx < frame_len) begin
            bit_idx = '0;
            shreg   = next_bus_byte();
            drive_bit();
          end else begin
            state = LINK_STOP_A; scl = 1'b0;
          end
        end
        LINK_STOP_A: begin
          state = LINK_STOP_B; scl = 1'b0; sda = 1'b0;
        end
        LINK_STOP_B: begin
          state = LINK_STOP_C; scl = 1'b1; sda = 1'b0;
        end
        LINK_STOP_C: begin
          frame = frame + 2'd1;
          scl   = 1'b1;
          sda   = 1'b1;
          if (frame == FRAME_END || frame == FRAME_DATA) begin
            frame = FRAME_DATA;
            state = LINK_IDLE;
            updates_done++;
          end else begin
            state = LINK_START_A;
          end
        end
        default: state = LINK_IDLE;
      endcase
    endfunction

    // Accepted input beat: advance the prediction and queue its result.
    function void note_beat(logic op, logic [15:0] digits);
      ssw_result_t r;
      r.accepted = 1'b0;
      if (op == OP_SHOW) begin
        if (state == LINK_IDLE) begin
          for (int k = 0; k < DIGIT_COUNT; k++) begin
            seg_bytes[k] = (k < INPUT_DIGITS) ? DIGIT_GLYPHS[digits[4*k +: 4]] : 8'h00;
          end
          frame      = FRAME_DATA;
          byte_idx   = '0;
          bit_idx    = '0;
          state      = LINK_ARMED;
          r.accepted = 1'b1;
          shows_taken++;
        end else begin
          shows_refused++;
        end
      end else if (state != LINK_IDLE) begin
        step_bus();
      end else begin
        idle_ticks++;
      end
      r.clock_line = scl;
      r.data_line  = sda;
      r.busy_res   = (state != LINK_IDLE);
      levels_q.push_back(r);
    endfunction

    // Result beat from the block: compare each field with the oldest prediction.
    function void check_result(logic [7:0] beat);
      ssw_result_t got;
      ssw_result_t want;
      got = ssw_result_t'(beat[3:0]);
      if (levels_q.size() == 0) begin
        log_mismatch("result beat with nothing pending", '0, beat);
        return;
      end
      want = levels_q.pop_front();
      beats_checked++;
      if (got.clock_line !== want.clock_line)
        log_mismatch("clock_line", want.clock_line, got.clock_line);
      if (got.data_line !== want.data_line)
        log_mismatch("data_line", want.data_line, got.data_line);
      if (got.busy_res !== want.busy_res)
        log_mismatch("busy_res", want.busy_res, got.busy_res);
      if (got.accepted !== want.accepted)
        log_mismatch("accepted", want.accepted, got.accepted);
    endfunction

    function void check_drained();
      if (levels_q.size() != 0) begin
        log_mismatch("result beats never delivered", '0, levels_q.size());
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // digit_first, digit_second, digit_third, digit_fourth
  logic [0:0]  in_tuser;   // operation
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // clock_line, data_line, busy_res, accepted, zero pad
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  link_scoreboard sb;
  bit sender_calm;
  int cycle_count;
  int config_writes;

  seven_segment_two_wire_writer uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 50 MHz clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Every result beat taken by the receiver goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata);
    end
  end

  // Receiver: random stalls with calm stretches, and one long hold-off.
  initial begin
    int stall;
    int beats_taken;
    bit rx_calm;
    beats_taken = 0;
    rx_calm     = 1'b0;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = rx_calm ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      beats_taken++;
      if (beats_taken % 40 == 0) begin
        rx_calm = !rx_calm;
      end
      // The sender keeps offering beats, so the block backs up and stalls its input.
      if (beats_taken == HOLD_AT_RESULT) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
    end
  end

  // One input beat, after a random gap unless the sender is in a calm stretch.
  task automatic send_beat(input logic op, input logic [15:0] digits);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= digits;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_beat(op, digits);
  endtask

  // Setup and access phases, then the select is dropped for an idle cycle.
  task automatic apb_access(input logic wr, input logic [2:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_register(input logic [2:0] addr, input logic [31:0] want);
    logic [31:0] rdata;
    apb_access(1'b0, addr, '0, rdata);
    if (rdata !== want) begin
      sb.log_mismatch($sformatf("register read at 0x%0h", addr), want, rdata);
    end
  endtask

  task automatic set_register(input logic [2:0] addr, input logic [31:0] value);
    logic [31:0] unused;
    apb_access(1'b1, addr, value, unused);
    sb.set_config(addr, value);
    config_writes++;
    check_register(addr, value);
  endtask

  // Stop offering beats and wait until every predicted result has come back.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly decimal digits, with blank codes now and then.
  function automatic logic [15:0] random_digits();
    logic [15:0] d;
    for (int k = 0; k < INPUT_DIGITS; k++) begin
      d[4*k +: 4] = ($urandom_range(0, 6) == 0) ? 4'($urandom_range(10, 15))
                                                : 4'($urandom_range(0, 9));
    end
    return d;
  endfunction

  // Main sequence: reset, directed beats, then phases of random traffic.
  initial begin
    logic        op;
    logic [2:0]  br;
    logic        en;
    sb = new();
    cycle_count   = 0;
    config_writes = 0;
    sender_calm   = 1'b0;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tuser    <= OP_TICK;
    in_tdata    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    check_register(BRIGHT_ADDR, 32'(BRIGHT_RESET));
    check_register(ENABLE_ADDR, 32'(DISP_EN_RESET));

    // Directed: idle tick, a request with edge digits, refused requests.
    send_beat(OP_TICK, 16'hFFFF);
    send_beat(OP_SHOW, {4'd15, 4'd9, 4'd0, 4'd8});
    send_beat(OP_SHOW, 16'h0000);
    repeat (6) send_beat(OP_TICK, 16'($urandom));
    send_beat(OP_SHOW, {4'd10, 4'd12, 4'd14, 4'd11});
    repeat (7) send_beat(OP_TICK, 16'($urandom));
    settle();

    // Changed mid-update, well before the control byte is loaded.
    set_register(BRIGHT_ADDR, 32'd0);
    set_register(ENABLE_ADDR, 32'd0);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin br = 3'd7; en = 1'b1; end
        1: begin br = 3'd0; en = 1'b1; end
        2: begin br = 3'd7; en = 1'b0; end
        default: begin
          br = 3'($urandom_range(0, 7));
          en = 1'($urandom_range(0, 1));
        end
      endcase
      set_register(BRIGHT_ADDR, 32'(br));
      set_register(ENABLE_ADDR, 32'(en));
      sender_calm = (ph % 3 == 1);

      // Well-formed updates: a request when idle, then ticks with a few
      // stray requests while busy and some idle ticks.
      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        if (!sb.is_busy()) begin
          op = ($urandom_range(0, 3) == 0) ? OP_TICK : OP_SHOW;
        end else begin
          op = ($urandom_range(0, 29) == 0) ? OP_SHOW : OP_TICK;
        end
        send_beat(op, (op == OP_SHOW) ? random_digits() : 16'($urandom));
      end
      settle();
    end

    repeat (10) @(posedge clk);
    sb.check_drained();

    $display("Run covered %0d updates sent in full, %0d requests taken, %0d refused,",
             sb.updates_done, sb.shows_taken, sb.shows_refused);
    $display("%0d idle ticks and %0d register writes; %0d result beats checked, %0d errors.",
             sb.idle_ticks, config_writes, sb.beats_checked, sb.mismatch_count);
    if (sb.mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/ssw_pkg.sv
hdl/ssw_cfg.sv
hdl/ssw_seq.sv
hdl/seven_segment_two_wire_writer.sv
tb/tb_seven_segment_two_wire_writer.sv
